// ----- rtl/hrlp_pkg.sv -----
// Package for the HTTP request line parser: phase codes, character codes,
// method and version name constants, the result beat type and small helpers.
// No dependencies; used by rtl/http_request_line_parser.sv and its checker.
package hrlp_pkg;

    // Default buffer size in bytes; the top level takes it as a parameter.
    localparam int MAX_REQUEST_BYTES_DEF = 4096;

    localparam int DATA_W        = 8;
    localparam int STATUS_W      = 2;
    localparam int METHOD_W      = 3;
    localparam int URI_W         = 12;
    localparam int LINE_W        = 13;
    localparam int TEXT_BYTES    = 8;
    localparam int TEXT_W        = TEXT_BYTES * DATA_W;
    localparam int TEXT_COUNT_W  = 4;
    localparam int NUM_METHODS   = 8;
    localparam int RESULT_W      = STATUS_W + METHOD_W + 2 * URI_W + LINE_W;
    localparam int OUT_TDATA_W   = ((RESULT_W + 7) / 8) * 8;

    localparam int URI_MAX       = (1 << URI_W) - 1;
    localparam int LINE_MAX      = (1 << LINE_W) - 1;

    // Parse phases.
    localparam logic [2:0] PH_METHOD     = 3'd0;
    localparam logic [2:0] PH_METHOD_SEP = 3'd1;
    localparam logic [2:0] PH_URI        = 3'd2;
    localparam logic [2:0] PH_URI_SEP    = 3'd3;
    localparam logic [2:0] PH_VERSION    = 3'd4;
    localparam logic [2:0] PH_DONE       = 3'd5;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_REQUEST = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_VERSION = 2'd2;

    // Character codes.
    localparam logic [DATA_W-1:0] CH_NUL   = 8'h00;
    localparam logic [DATA_W-1:0] CH_LF    = 8'h0A;
    localparam logic [DATA_W-1:0] CH_CR    = 8'h0D;
    localparam logic [DATA_W-1:0] CH_SPACE = 8'h20;
    localparam logic [DATA_W-1:0] CH_UPPER_A = 8'd65;
    localparam logic [DATA_W-1:0] CH_UPPER_Z = 8'd90;
    localparam logic [DATA_W-1:0] CASE_OFFSET = 8'd32;

    // Lower-case names, first character in the lowest byte, zero padded.
    localparam logic [TEXT_W-1:0] METHOD_NAMES [NUM_METHODS] = '{
        64'h0000_0000_0074_6567,   // get
        64'h0000_0000_7473_6f70,   // post
        64'h0000_0000_0074_7570,   // put
        64'h0000_6574_656c_6564,   // delete
        64'h0074_6365_6e6e_6f63,   // connect
        64'h0000_0065_6361_7274,   // trace
        64'h0000_0000_6461_6568,   // head
        64'h0073_6e6f_6974_706f    // options
    };
    localparam logic [TEXT_COUNT_W-1:0] METHOD_LENS [NUM_METHODS] = '{
        4'd3, 4'd4, 4'd3, 4'd6, 4'd7, 4'd5, 4'd4, 4'd7
    };
    localparam logic [TEXT_W-1:0] VERSION_NAME = 64'h312e_312f_7074_7468; // http/1.1

    typedef struct packed {
        logic [LINE_W-1:0]   line_length;
        logic [URI_W-1:0]    uri_length;
        logic [URI_W-1:0]    uri_start;
        logic [METHOD_W-1:0] method_code;
        logic [STATUS_W-1:0] status;
    } result_t;

    typedef struct packed {
        logic                hit;
        logic [METHOD_W-1:0] code;
    } method_match_t;

    function automatic logic [DATA_W-1:0] fold_case(input logic [DATA_W-1:0] c);
        logic [DATA_W-1:0] r;
        r = c;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
        begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

    // Text bytes past the count are always zero, so a whole-word compare
    // together with the count decides a match.
    function automatic method_match_t method_lookup(input logic [TEXT_W-1:0] text,
                                                    input logic [TEXT_COUNT_W-1:0] count);
        method_match_t r;
        r = '0;
        for (int m = NUM_METHODS - 1; m >= 0; m--)
        begin
            if (count == METHOD_LENS[m] && text == METHOD_NAMES[m])
            begin
                r.hit  = 1'b1;
                r.code = METHOD_W'(m);
            end
        end
        return r;
    endfunction

endpackage

// ----- rtl/http_request_line_parser.sv -----
// HTTP request line parser, top level: byte stream in, one verdict beat out.
// Depends on rtl/hrlp_pkg.sv.
//
//  Channel  Direction  Payload                                      Beat meaning
//  s_*      in         tdata[7:0] data_byte, tlast last_byte         one request byte
//  m_*      out        tdata[1:0] status, [4:2] method_code,         one verdict
//                      [16:5] uri_start, [28:17] uri_length,
//                      [41:29] line_length, [47:42] zero
//
// The parse state and the result are both updated in the cycle a byte is
// accepted, so a byte can be taken on every clock while s_tready is high.
// A verdict is registered (result or skid register) before it shows on m_tvalid.
// Reset (rst_n low, asynchronous) returns the parser to the method phase at
// position zero and empties the output stage; no clearing pass is needed.
// The output side has a result register plus a one-entry skid register;
// s_tready only drops while both hold a verdict, so input bytes keep flowing
// while one verdict waits on a stalled m_tready.
module http_request_line_parser #(
    parameter int MAX_REQUEST_BYTES = hrlp_pkg::MAX_REQUEST_BYTES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [hrlp_pkg::DATA_W-1:0]       s_tdata,   // [7:0] data_byte
    input  logic                              s_tlast,   // last_byte
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [1:0] status, [4:2] method_code, [16:5] uri_start, [28:17] uri_length,
    // [41:29] line_length, rest zero
    output logic [hrlp_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    // The position counter must hold MAX_REQUEST_BYTES itself, where it stops.
    localparam int POS_W = $clog2(MAX_REQUEST_BYTES + 1);

    // Parse state.
    logic [2:0]                              phase_reg, phase_next;
    logic [POS_W-1:0]                        pos_reg, pos_next;
    logic [hrlp_pkg::TEXT_W-1:0]             method_text_reg, method_text_next;
    logic [hrlp_pkg::TEXT_COUNT_W-1:0]       method_count_reg, method_count_next;
    logic [hrlp_pkg::TEXT_W-1:0]             version_text_reg, version_text_next;
    logic [hrlp_pkg::TEXT_COUNT_W-1:0]       version_count_reg, version_count_next;
    logic [hrlp_pkg::URI_W-1:0]              uri_offset_reg, uri_offset_next;
    logic [hrlp_pkg::URI_W-1:0]              uri_count_reg, uri_count_next;
    logic                                    carriage_reg, carriage_next;
    logic [hrlp_pkg::METHOD_W-1:0]           method_code_reg, method_code_next;

    // Output stage: result register and skid register.
    logic                                    out_valid_reg, out_valid_next;
    hrlp_pkg::result_t                       out_data_reg, out_data_next;
    logic                                    skid_valid_reg, skid_valid_next;
    hrlp_pkg::result_t                       skid_data_reg, skid_data_next;

    logic                                    accept;
    logic                                    take;
    logic [hrlp_pkg::DATA_W-1:0]             c;
    logic [hrlp_pkg::DATA_W-1:0]             c_folded;
    logic [31:0]                             pos_wide;
    logic                                    forced;
    logic                                    emit_bad;
    logic                                    emit_line;
    logic                                    version_ok;
    hrlp_pkg::method_match_t                 mmatch;
    hrlp_pkg::result_t                       result;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign take     = out_valid_reg && m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = hrlp_pkg::OUT_TDATA_W'(out_data_reg);

    assign c        = s_tdata;
    assign c_folded = hrlp_pkg::fold_case(s_tdata);
    assign pos_wide = 32'(pos_reg);
    // The byte at the last buffer position counts as the final byte.
    assign forced   = (pos_wide + 32'd1) >= 32'(MAX_REQUEST_BYTES);

    assign mmatch     = hrlp_pkg::method_lookup(method_text_reg, method_count_reg);
    assign version_ok = (version_count_reg == hrlp_pkg::TEXT_COUNT_W'(hrlp_pkg::TEXT_BYTES))
                        && (version_text_reg == hrlp_pkg::VERSION_NAME);

    // Per-byte parse step.
    always_comb
    begin
        phase_next         = phase_reg;
        pos_next           = pos_reg;
        method_text_next   = method_text_reg;
        method_count_next  = method_count_reg;
        version_text_next  = version_text_reg;
        version_count_next = version_count_reg;
        uri_offset_next    = uri_offset_reg;
        uri_count_next     = uri_count_reg;
        carriage_next      = carriage_reg;
        method_code_next   = method_code_reg;
        emit_bad           = 1'b0;
        emit_line          = 1'b0;

        if (accept)
        begin
            if (phase_reg != hrlp_pkg::PH_DONE)
            begin
                if (c == hrlp_pkg::CH_NUL)
                begin
                    emit_bad = 1'b1;
                end
                else
                begin
                    case (phase_reg)
                        hrlp_pkg::PH_METHOD:
                        begin
                            if (c == hrlp_pkg::CH_SPACE)
                            begin
                                phase_next = hrlp_pkg::PH_METHOD_SEP;
                            end
                            else
                            begin
                                for (int k = 0; k < hrlp_pkg::TEXT_BYTES; k++)
                                begin
                                    if (method_count_reg == hrlp_pkg::TEXT_COUNT_W'(k))
                                    begin
                                        method_text_next[8*k +: 8] = c_folded;
                                    end
                                end
                                if (method_count_reg <= hrlp_pkg::TEXT_COUNT_W'(hrlp_pkg::TEXT_BYTES))
                                begin
                                    method_count_next = method_count_reg + 1'b1;
                                end
                            end
                        end
                        hrlp_pkg::PH_METHOD_SEP:
                        begin
                            if (c == hrlp_pkg::CH_SPACE || !mmatch.hit)
                            begin
                                emit_bad = 1'b1;
                            end
                            else
                            begin
                                method_code_next = mmatch.code;
                                uri_offset_next  = (pos_wide > 32'(hrlp_pkg::URI_MAX))
                                                   ? hrlp_pkg::URI_W'(hrlp_pkg::URI_MAX)
                                                   : hrlp_pkg::URI_W'(pos_wide);
                                uri_count_next   = hrlp_pkg::URI_W'(1);
                                phase_next       = hrlp_pkg::PH_URI;
                            end
                        end
                        hrlp_pkg::PH_URI:
                        begin
                            if (c == hrlp_pkg::CH_SPACE)
                            begin
                                phase_next = hrlp_pkg::PH_URI_SEP;
                            end
                            else if (uri_count_reg != hrlp_pkg::URI_W'(hrlp_pkg::URI_MAX))
                            begin
                                uri_count_next = uri_count_reg + 1'b1;
                            end
                        end
                        hrlp_pkg::PH_URI_SEP, hrlp_pkg::PH_VERSION:
                        begin
                            // The byte after the second space is already the
                            // first version byte.
                            if (phase_reg == hrlp_pkg::PH_URI_SEP && c == hrlp_pkg::CH_SPACE)
                            begin
                                emit_bad = 1'b1;
                            end
                            else
                            begin
                                phase_next = hrlp_pkg::PH_VERSION;
                                if (carriage_reg)
                                begin
                                    if (c == hrlp_pkg::CH_LF)
                                    begin
                                        emit_line = 1'b1;
                                    end
                                    else
                                    begin
                                        emit_bad = 1'b1;
                                    end
                                end
                                else if (c == hrlp_pkg::CH_CR)
                                begin
                                    carriage_next = 1'b1;
                                end
                                else if (c == hrlp_pkg::CH_LF)
                                begin
                                    emit_line = 1'b1;
                                end
                                else
                                begin
                                    for (int k = 0; k < hrlp_pkg::TEXT_BYTES; k++)
                                    begin
                                        if (version_count_reg == hrlp_pkg::TEXT_COUNT_W'(k))
                                        begin
                                            version_text_next[8*k +: 8] = c_folded;
                                        end
                                    end
                                    if (version_count_reg <= hrlp_pkg::TEXT_COUNT_W'(hrlp_pkg::TEXT_BYTES))
                                    begin
                                        version_count_next = version_count_reg + 1'b1;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end

                // The data ran out before the line was complete.
                if (!emit_bad && !emit_line && (s_tlast || forced))
                begin
                    emit_bad = 1'b1;
                end
                if (emit_bad || emit_line)
                begin
                    phase_next = hrlp_pkg::PH_DONE;
                end
            end

            if (pos_wide < 32'(MAX_REQUEST_BYTES))
            begin
                pos_next = pos_reg + 1'b1;
            end

            if (s_tlast)
            begin
                phase_next         = hrlp_pkg::PH_METHOD;
                pos_next           = '0;
                method_text_next   = '0;
                method_count_next  = '0;
                version_text_next  = '0;
                version_count_next = '0;
                uri_offset_next    = '0;
                uri_count_next     = '0;
                carriage_next      = 1'b0;
                method_code_next   = '0;
            end
            else if (forced)
            begin
                phase_next = hrlp_pkg::PH_DONE;
            end
        end
    end

    // Verdict for the current byte.
    always_comb
    begin
        result = '0;
        if (emit_bad)
        begin
            result.status = hrlp_pkg::ST_BAD_REQUEST;
        end
        else
        begin
            result.status      = version_ok ? hrlp_pkg::ST_OK : hrlp_pkg::ST_BAD_VERSION;
            result.method_code = method_code_reg;
            result.uri_start   = uri_offset_reg;
            result.uri_length  = uri_count_reg;
            result.line_length = ((pos_wide + 32'd1) > 32'(hrlp_pkg::LINE_MAX))
                                 ? hrlp_pkg::LINE_W'(hrlp_pkg::LINE_MAX)
                                 : hrlp_pkg::LINE_W'(pos_wide + 32'd1);
        end
    end

    // Output stage. A new verdict only arrives while the skid register is
    // empty, because s_tready is low otherwise.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = emit_bad || emit_line;
                out_data_next  = result;
            end
        end
        else if (emit_bad || emit_line)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= hrlp_pkg::PH_METHOD;
            pos_reg           <= '0;
            method_text_reg   <= '0;
            method_count_reg  <= '0;
            version_text_reg  <= '0;
            version_count_reg <= '0;
            uri_offset_reg    <= '0;
            uri_count_reg     <= '0;
            carriage_reg      <= 1'b0;
            method_code_reg   <= '0;
            out_valid_reg     <= 1'b0;
            skid_valid_reg    <= 1'b0;
        end
        else
        begin
            phase_reg         <= phase_next;
            pos_reg           <= pos_next;
            method_text_reg   <= method_text_next;
            method_count_reg  <= method_count_next;
            version_text_reg  <= version_text_next;
            version_count_reg <= version_count_next;
            uri_offset_reg    <= uri_offset_next;
            uri_count_reg     <= uri_count_next;
            carriage_reg      <= carriage_next;
            method_code_reg   <= method_code_next;
            out_valid_reg     <= out_valid_next;
            skid_valid_reg    <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// ----- rtl/hrlp_checker.sv -----
// Port-level checker for the HTTP request line parser, with its bind statement.
// Depends on rtl/hrlp_pkg.sv and rtl/http_request_line_parser.sv.
module hrlp_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [hrlp_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    // A stalled verdict beat keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("verdict beat changed while stalled");

    // A bad request carries zero fields, and the padding is always zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] == hrlp_pkg::ST_BAD_REQUEST |-> m_tdata[47:2] == '0)
        else $error("bad request beat has nonzero fields");

    // No status code beyond version not supported, and the padding is zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[1:0] != 2'd3 && m_tdata[47:42] == '0)
        else $error("illegal status or padding in verdict beat");

    // A parsed line has a method of three or more bytes and a space before
    // the URI, a nonempty URI and a line that ends past the URI start.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] == hrlp_pkg::ST_OK || m_tdata[1:0] == hrlp_pkg::ST_BAD_VERSION)
        |-> m_tdata[16:5] >= 12'd4 && m_tdata[28:17] != '0 && m_tdata[41:29] > 13'(m_tdata[16:5]))
        else $error("parsed line has inconsistent positions");

endmodule

bind http_request_line_parser hrlp_checker u_hrlp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
